// ===== rtl/core/tle_record_integrity_checker_defines.svh =====
// Assertion macros shared by the record integrity checker RTL.
`ifndef TLE_RECORD_INTEGRITY_CHECKER_DEFINES_SVH
`define TLE_RECORD_INTEGRITY_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TRIC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TRIC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define TRIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/tric_pkg.sv =====
// Shared types, constants and helpers of the record integrity checker.
`default_nettype none

package tric_pkg;

    localparam int unsigned RESULT_DATA_W = 24;
    localparam int unsigned ID_W          = 17;
    localparam int unsigned WEIGHT_W      = 14;

    // Register index of lines_per_set on the configuration port.
    localparam logic REG_LINES_PER_SET = 1'b0;

    typedef struct packed {
        logic        lead1_bad;
        logic        lead2_bad;
        logic        class_bad;
        logic        model_bad;
        logic        sum1_bad;
        logic        sum2_bad;
        logic        id_mismatch;
        logic        record_bad;
        logic [15:0] record_number;
    } result_t;

    // Decimal weight of an object number digit, by its place in columns 2..6.
    function automatic logic [WEIGHT_W-1:0] id_weight(input logic [2:0] place);
        logic [WEIGHT_W-1:0] w;
        case (place)
            3'd0:    w = 14'd10000;
            3'd1:    w = 14'd1000;
            3'd2:    w = 14'd100;
            3'd3:    w = 14'd10;
            3'd4:    w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

    // Stream word of a result, first field in the lowest bit.
    function automatic logic [RESULT_DATA_W-1:0] pack_result(input result_t r);
        return {r.record_number, r.record_bad, r.id_mismatch, r.sum2_bad, r.sum1_bad,
                r.model_bad, r.class_bad, r.lead2_bad, r.lead1_bad};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tric_core.sv =====
// Per-character line state, checksum and field checks of the record checker.
`default_nettype none

module tric_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic [7:0]       ch,
    input  wire logic             line_end,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_data,
    output logic [1:0]            lines_per_set,
    output logic                  produced,
    output tric_pkg::result_t     res
);

    localparam logic [1:0] LINE_NAME = 2'd0;
    localparam logic [1:0] LINE_ONE  = 2'd1;
    localparam logic [1:0] LINE_TWO  = 2'd2;

    localparam logic [6:0] COL_ID_FIRST = 7'd2;
    localparam logic [6:0] COL_ID_LAST  = 7'd6;
    localparam logic [6:0] COL_CLASS    = 7'd7;
    localparam logic [6:0] COL_MODEL    = 7'd62;
    localparam logic [6:0] COL_CHECK    = 7'd68;
    localparam logic [6:0] COL_MAX      = 7'd127;

    localparam logic [2:0] F_LEAD1 = 3'd0;
    localparam logic [2:0] F_LEAD2 = 3'd1;
    localparam logic [2:0] F_CLASS = 3'd2;
    localparam logic [2:0] F_MODEL = 3'd3;
    localparam logic [2:0] F_SUM1  = 3'd4;
    localparam logic [2:0] F_SUM2  = 3'd5;
    localparam logic [2:0] F_ID    = 3'd6;

    localparam logic [1:0] LPS_RESET   = 2'd3;
    localparam logic [1:0] LPS_NO_NAME = 2'd2;

    logic [1:0]               lps_reg;
    logic [6:0]               column_reg, column_next;
    logic [1:0]               line_reg, line_next;
    logic [3:0]               sum_reg, sum_next;
    logic [tric_pkg::ID_W-1:0] first_id_reg, first_id_next;
    logic [tric_pkg::ID_W-1:0] cur_id_reg, cur_id_next;
    logic [6:0]               flags_reg, flags_next;
    logic [15:0]              count_reg, count_next;

    logic [3:0]               digit;
    logic                     in_line;
    logic                     l1;
    logic [3:0]               add;
    logic [4:0]               sum_raw;
    logic [3:0]               sum_mod;
    logic [6:0]               flags_upd;
    logic [6:0]               flags_out;
    logic [tric_pkg::ID_W-1:0] id_upd;
    logic [tric_pkg::ID_W-1:0] id_prod;
    logic [2:0]               id_place;
    logic [1:0]               first_line;
    logic [1:0]               restart_line;

    assign lines_per_set = lps_reg;
    assign first_line    = (lps_reg == LPS_NO_NAME) ? LINE_ONE : LINE_NAME;
    assign restart_line  = (cfg_data == LPS_NO_NAME) ? LINE_ONE : LINE_NAME;

    // Non-digits read as zero; an ASCII digit's low nibble is its value.
    assign digit   = (ch >= "0" && ch <= "9") ? ch[3:0] : 4'd0;
    assign in_line = (line_reg == LINE_ONE) || (line_reg == LINE_TWO);
    assign l1      = (line_reg == LINE_ONE);

    assign id_place = 3'(column_reg - COL_ID_FIRST);
    assign id_prod  = tric_pkg::ID_W'(digit) * tric_pkg::ID_W'(tric_pkg::id_weight(id_place));

    always_comb begin
        if (l1 && ch == "-") begin
            add = 4'd1;
        end else if (l1 && (column_reg == COL_CLASS || column_reg inside {[7'd14:7'd16]})) begin
            add = 4'd0;
        end else begin
            add = digit;
        end
        sum_raw = {1'b0, sum_reg} + {1'b0, add};
        sum_mod = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

        flags_upd = flags_reg;
        id_upd    = cur_id_reg;
        if (in_line) begin
            if (column_reg == 7'd0 && digit != (l1 ? 4'd1 : 4'd2)) begin
                flags_upd[l1 ? F_LEAD1 : F_LEAD2] = 1'b1;
            end
            if (column_reg >= COL_ID_FIRST && column_reg <= COL_ID_LAST) begin
                id_upd = cur_id_reg + id_prod;
            end
            if (l1 && column_reg == COL_CLASS && ch != "U" && ch != "C") begin
                flags_upd[F_CLASS] = 1'b1;
            end
            if (l1 && column_reg == COL_MODEL && digit != 4'd0) begin
                flags_upd[F_MODEL] = 1'b1;
            end
            if (column_reg == COL_CHECK && digit != sum_reg) begin
                flags_upd[l1 ? F_SUM1 : F_SUM2] = 1'b1;
            end
            if (line_end) begin
                // A line that stops short never reached its check digit.
                if (column_reg < COL_CHECK) begin
                    flags_upd[l1 ? F_SUM1 : F_SUM2] = 1'b1;
                end
                if (l1 && column_reg < COL_CLASS) begin
                    flags_upd[F_CLASS] = 1'b1;
                end
            end
        end

        flags_out = flags_upd;
        if (first_id_reg != id_upd) begin
            flags_out[F_ID] = 1'b1;
        end

        res.lead1_bad     = flags_out[F_LEAD1];
        res.lead2_bad     = flags_out[F_LEAD2];
        res.class_bad     = flags_out[F_CLASS];
        res.model_bad     = flags_out[F_MODEL];
        res.sum1_bad      = flags_out[F_SUM1];
        res.sum2_bad      = flags_out[F_SUM2];
        res.id_mismatch   = flags_out[F_ID];
        res.record_bad    = |flags_out;
        res.record_number = count_reg;

        produced = step && line_end && (line_reg == LINE_TWO);

        column_next   = (column_reg < COL_MAX) ? column_reg + 7'd1 : column_reg;
        line_next     = line_reg;
        sum_next      = (in_line && column_reg < COL_CHECK) ? sum_mod : sum_reg;
        first_id_next = first_id_reg;
        cur_id_next   = id_upd;
        flags_next    = flags_upd;
        count_next    = count_reg;

        if (line_end) begin
            if (line_reg == LINE_ONE) begin
                first_id_next = id_upd;
            end else if (line_reg == LINE_TWO) begin
                count_next = count_reg + 16'd1;
            end
            column_next = 7'd0;
            sum_next    = 4'd0;
            cur_id_next = '0;
            if (line_reg >= LINE_TWO) begin
                line_next     = first_line;
                first_id_next = '0;
                flags_next    = '0;
            end else begin
                line_next = line_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lps_reg      <= LPS_RESET;
            column_reg   <= '0;
            line_reg     <= LINE_NAME;
            sum_reg      <= '0;
            first_id_reg <= '0;
            cur_id_reg   <= '0;
            flags_reg    <= '0;
            count_reg    <= '0;
        end else if (cfg_we) begin
            // A register write restarts the set; the record count is kept.
            lps_reg      <= cfg_data;
            column_reg   <= '0;
            line_reg     <= restart_line;
            sum_reg      <= '0;
            first_id_reg <= '0;
            cur_id_reg   <= '0;
            flags_reg    <= '0;
        end else if (step) begin
            column_reg   <= column_next;
            line_reg     <= line_next;
            sum_reg      <= sum_next;
            first_id_reg <= first_id_next;
            cur_id_reg   <= cur_id_next;
            flags_reg    <= flags_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tle_record_integrity_checker.sv =====
// Top level of the record integrity checker: stream ports, register port, stages.
//
//  Channel  Direction  Payload
//  -------  ---------  ----------------------------------------------------------
//  s_       in         tdata[7:0] ch, tlast line_end
//  m_       out        tdata[23:0] seven error flags, record_bad, record_number
//  APB      in/out     register 0 lines_per_set at byte address 0
//
// One character item per cycle while a waiting result is not stalled by m_tready.
// Each item is held in the input register; the checks and state update sit between
// it and the result register, which then offers the result of a line 2 end item.
// A waiting result only blocks the input once the input register is also full.
// Reset is synchronous; no clearing pass is needed.
`default_nettype none

`include "tle_record_integrity_checker_defines.svh"

module tle_record_integrity_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream: tdata = ch[7:0]; tlast = line_end.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // Result stream: tdata = lead1_bad, lead2_bad, class_bad, model_bad, sum1_bad,
    // sum2_bad, id_mismatch, record_bad, record_number[15:0] from bit 0 up.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic              in_valid_reg;
    logic [7:0]        ch_reg;
    logic              end_reg;
    logic              out_valid_reg;
    tric_pkg::result_t res_reg;

    logic              advance;
    logic              cfg_we;
    logic              produced;
    logic [1:0]        lines_per_set;
    tric_pkg::result_t core_res;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready
                     && (paddr[2] == tric_pkg::REG_LINES_PER_SET);
    assign prdata  = (paddr[2] == tric_pkg::REG_LINES_PER_SET) ?
                     {30'd0, lines_per_set} : 32'd0;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tric_pkg::pack_result(res_reg);

    tric_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .ch            (ch_reg),
        .line_end      (end_reg),
        .cfg_we        (cfg_we),
        .cfg_data      (pwdata[1:0]),
        .lines_per_set (lines_per_set),
        .produced      (produced),
        .res           (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (produced) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg  <= s_tdata;
            end_reg <= s_tlast;
        end
        if (produced) begin
            res_reg <= core_res;
        end
    end

    `TRIC_ASSERT_NEXT(a_result_kept, aclk, aresetn, produced,
        m_tvalid && (m_tdata == $past(tric_pkg::pack_result(core_res))),
        "result item lost or altered on its way out")

    `TRIC_ASSERT_SAME(a_stall_cause, aclk, aresetn, !s_tready,
        in_valid_reg && m_tvalid && !m_tready,
        "input stalled without a blocked result")

    `TRIC_ASSERT_SAME(a_record_bad_or, aclk, aresetn, m_tvalid,
        m_tdata[7] == (|m_tdata[6:0]),
        "record_bad does not match the error flags")

endmodule

`default_nettype wire

// ===== test/tle_record_integrity_checker_tb.sv =====
// Self-checking testbench for the TLE record integrity checker: stream traffic, register writes.
`timescale 1ns / 100ps

module tle_record_integrity_checker_tb;

    localparam int CHECK_COL   = 68;
    localparam int CLASS_COL   = 7;
    localparam int MODEL_COL   = 62;
    localparam int COL_LIMIT   = 127;
    localparam int LINE_LEN    = CHECK_COL + 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 180;
    localparam int PHASE_RECORDS = 2;

    // Positions of the error flags, in the order they sit in m_tdata.
    localparam int FLAG_LEAD1 = 0;
    localparam int FLAG_LEAD2 = 1;
    localparam int FLAG_CLASS = 2;
    localparam int FLAG_MODEL = 3;
    localparam int FLAG_SUM1  = 4;
    localparam int FLAG_SUM2  = 5;
    localparam int FLAG_ID    = 6;

    localparam logic [1:0] LINE_NAME = 2'd0;
    localparam logic [1:0] LINE_ONE  = 2'd1;
    localparam logic [1:0] LINE_TWO  = 2'd2;

    localparam logic [1:0] LPS_NO_NAME   = 2'd2;
    localparam logic [1:0] LPS_WITH_NAME = 2'd3;

    localparam logic [2:0] LPS_ADDR   = {tric_pkg::REG_LINES_PER_SET, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    localparam logic [1:0] PHASE_LPS [PHASES] = '{
        LPS_NO_NAME, 2'd0, LPS_WITH_NAME, 2'd1, LPS_NO_NAME, LPS_WITH_NAME
    };

    // Row layout: {typed, flags[6:0], line_end, ch}. Typed rows carry the flags of the
    // record that their line end closes; the record number counts up from reset.
    localparam logic [16:0] DIRECTED_ROWS [22] = '{
        {1'b0, 7'h00, 1'b1, 8'hFF},
        {1'b0, 7'h00, 1'b1, 8'h00},
        {1'b1, 7'h37, 1'b1, 8'hFF},
        {1'b0, 7'h00, 1'b1, 8'h41},
        {1'b0, 7'h00, 1'b1, 8'h31},
        {1'b1, 7'h34, 1'b1, 8'h32},
        {1'b0, 7'h00, 1'b1, 8'h20},
        {1'b0, 7'h00, 1'b0, 8'h31},
        {1'b0, 7'h00, 1'b0, 8'h20},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h31},
        {1'b0, 7'h00, 1'b1, 8'h55},
        {1'b0, 7'h00, 1'b0, 8'h32},
        {1'b0, 7'h00, 1'b0, 8'h20},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b0, 7'h00, 1'b0, 8'h30},
        {1'b1, 7'h70, 1'b1, 8'h32}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // ch[7:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // lead1, lead2, class, model, sum1, sum2, id, record_bad, number
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tle_record_integrity_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Checker state as the block should hold it.
    logic [1:0]  lines_cfg;
    logic [6:0]  col_pos;
    logic [1:0]  line_no;
    int unsigned digit_acc;
    int unsigned id_first;
    int unsigned id_now;
    logic [6:0]  err_flags;
    logic [15:0] record_cnt;

    tric_pkg::result_t records_due [$];
    int mismatches;
    int directed_records;
    int phase_items;
    int phase_records;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int hold_served;

    logic [7:0] line_buf [0:159];
    int line_len;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tle_record_integrity_checker test failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic logic [1:0] first_line();
        return (lines_cfg == LPS_NO_NAME) ? LINE_ONE : LINE_NAME;
    endfunction

    function automatic tric_pkg::result_t record_from_flags(input logic [6:0] f,
                                                            input logic [15:0] num);
        tric_pkg::result_t r;
        r.lead1_bad     = f[FLAG_LEAD1];
        r.lead2_bad     = f[FLAG_LEAD2];
        r.class_bad     = f[FLAG_CLASS];
        r.model_bad     = f[FLAG_MODEL];
        r.sum1_bad      = f[FLAG_SUM1];
        r.sum2_bad      = f[FLAG_SUM2];
        r.id_mismatch   = f[FLAG_ID];
        r.record_bad    = |f;
        r.record_number = num;
        return r;
    endfunction

    task automatic restart_set();
        col_pos   = '0;
        line_no   = first_line();
        digit_acc = 0;
        id_first  = 0;
        id_now    = 0;
        err_flags = '0;
    endtask

    // Advances the checker state by one character and returns the record it closes.
    task automatic track_char(input logic [7:0] ch, input logic last,
                              output bit produced, output tric_pkg::result_t rec);
        int unsigned col;
        int unsigned d;
        int sum_flag;
        bit l1;
        logic [6:0] f;
        col      = col_pos;
        d        = (ch >= "0" && ch <= "9") ? ch - "0" : 0;
        l1       = (line_no == LINE_ONE);
        sum_flag = l1 ? FLAG_SUM1 : FLAG_SUM2;
        produced = 1'b0;
        rec      = '0;
        if (line_no == LINE_ONE || line_no == LINE_TWO) begin
            if (col < CHECK_COL) begin
                // On line 1 a minus counts one, and the class and 14..16 columns count nothing.
                if (l1 && ch == "-")
                    digit_acc = (digit_acc + 1) % 10;
                else if (!(l1 && (col == CLASS_COL || (col >= 14 && col <= 16))))
                    digit_acc = (digit_acc + d) % 10;
            end
            if (col == 0 && d != (l1 ? 1 : 2))
                err_flags[l1 ? FLAG_LEAD1 : FLAG_LEAD2] = 1'b1;
            if (col >= 2 && col <= 6)
                id_now += d * (10 ** (6 - col));
            if (l1 && col == CLASS_COL && ch != "U" && ch != "C")
                err_flags[FLAG_CLASS] = 1'b1;
            if (l1 && col == MODEL_COL && d != 0)
                err_flags[FLAG_MODEL] = 1'b1;
            if (col == CHECK_COL && d != digit_acc)
                err_flags[sum_flag] = 1'b1;
            if (last) begin
                if (col < CHECK_COL)
                    err_flags[sum_flag] = 1'b1;
                if (l1 && col < CLASS_COL)
                    err_flags[FLAG_CLASS] = 1'b1;
            end
        end
        if (col < COL_LIMIT)
            col_pos = 7'(col + 1);
        if (last) begin
            if (line_no == LINE_ONE) begin
                id_first = id_now;
            end else if (line_no == LINE_TWO) begin
                f = err_flags;
                if (id_first != id_now)
                    f[FLAG_ID] = 1'b1;
                rec        = record_from_flags(f, record_cnt);
                record_cnt = record_cnt + 16'd1;
                produced   = 1'b1;
            end
            col_pos   = '0;
            digit_acc = 0;
            id_now    = 0;
            if (line_no >= LINE_TWO) begin
                line_no   = first_line();
                id_first  = 0;
                err_flags = '0;
            end else begin
                line_no = line_no + 2'd1;
            end
        end
    endtask

    task automatic send_item(input logic [7:0] ch, input logic last,
                             input bit typed = 1'b0, input logic [6:0] typed_flags = '0);
        bit produced;
        tric_pkg::result_t rec;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_char(ch, last, produced, rec);
        if (produced) begin
            if (typed) begin
                rec = record_from_flags(typed_flags, 16'(directed_records));
                directed_records++;
            end
            records_due = {records_due, rec};
            phase_records++;
        end
        phase_items++;
    endtask

    task automatic send_line();
        for (int k = 0; k < line_len; k++)
            send_item(line_buf[k], k == line_len - 1);
    endtask

    // Fills line_buf with a well-formed line, then sometimes breaks parts of it; chop cuts it short.
    task automatic build_line(input int which, input int obj, input bit chop);
        int pick;
        int acc;
        int n;
        for (int k = 0; k < LINE_LEN; k++) begin
            pick = $urandom_range(99);
            if (pick < 60)
                line_buf[k] = 8'("0" + $urandom_range(9));
            else if (pick < 75)
                line_buf[k] = " ";
            else if (pick < 83)
                line_buf[k] = "-";
            else if (pick < 88)
                line_buf[k] = ".";
            else if (pick < 93)
                line_buf[k] = "+";
            else
                line_buf[k] = 8'($urandom_range(255));
        end
        line_buf[0] = 8'("0" + which);
        line_buf[1] = " ";
        for (int k = 0; k < 5; k++)
            line_buf[2 + k] = 8'("0" + (obj / (10 ** (4 - k))) % 10);
        // A leading zero of the object number may also be written as a space.
        if (obj < 10000 && $urandom_range(1) == 1)
            line_buf[2] = " ";
        if (which == 1) begin
            line_buf[CLASS_COL] = $urandom_range(1) ? "U" : "C";
            line_buf[MODEL_COL] = "0";
        end
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0:       line_buf[0] = 8'($urandom_range(255));
                1:       line_buf[CLASS_COL] = 8'($urandom_range(255));
                default: line_buf[MODEL_COL] = 8'("0" + $urandom_range(9));
            endcase
        end
        acc = 0;
        for (int k = 0; k < CHECK_COL; k++) begin
            if (which == 1 && line_buf[k] == "-")
                acc += 1;
            else if (!(which == 1 && (k == CLASS_COL || (k >= 14 && k <= 16)))
                     && line_buf[k] >= "0" && line_buf[k] <= "9")
                acc += line_buf[k] - "0";
        end
        line_buf[CHECK_COL] = 8'("0" + acc % 10);
        line_len = LINE_LEN;
        if (chop) begin
            line_len = $urandom_range(1, 20);
        end else if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
                0: line_buf[$urandom_range(CHECK_COL)] = 8'($urandom_range(255));
                1: line_buf[CHECK_COL] = 8'("0" + (acc + $urandom_range(1, 9)) % 10);
                2: line_len = $urandom_range(1, CHECK_COL);
                default: begin
                    // Long enough at times to run the column count into saturation.
                    n = $urandom_range(1, 70);
                    for (int k = 0; k < n; k++)
                        line_buf[LINE_LEN + k] = 8'($urandom_range(255));
                    line_len = LINE_LEN + n;
                end
            endcase
        end
    endtask

    task automatic send_random_set();
        int pick;
        int obj;
        int n;
        while (line_no != first_line())
            send_item(8'($urandom_range(255)), 1'b1);
        pick = $urandom_range(99);
        if (pick < 15) begin
            n = $urandom_range(5, 40);
            for (int k = 0; k < n; k++)
                send_item(8'($urandom_range(255)), $urandom_range(5) == 0);
        end else begin
            obj = $urandom_range(99999);
            if (line_no == LINE_NAME) begin
                n = $urandom_range(1, 24);
                for (int k = 0; k < n; k++)
                    send_item(8'($urandom_range(255)), k == n - 1);
            end
            build_line(1, obj, pick < 50);
            send_line();
            if ($urandom_range(15) == 0)
                obj = $urandom_range(99999);
            build_line(2, obj, pick < 50);
            send_line();
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        // A write to the register also starts the current set over.
        if (addr == LPS_ADDR) begin
            lines_cfg = data[1:0];
            restart_set();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (records_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        tric_pkg::result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (records_due.size() == 0) begin
                    flag_mismatch($sformatf("record %0d arrived with none pending",
                                            m_tdata[23:8]));
                end else begin
                    want = records_due.pop_front();
                    check_field("lead1_bad", 16'(m_tdata[0]), 16'(want.lead1_bad));
                    check_field("lead2_bad", 16'(m_tdata[1]), 16'(want.lead2_bad));
                    check_field("class_bad", 16'(m_tdata[2]), 16'(want.class_bad));
                    check_field("model_bad", 16'(m_tdata[3]), 16'(want.model_bad));
                    check_field("sum1_bad", 16'(m_tdata[4]), 16'(want.sum1_bad));
                    check_field("sum2_bad", 16'(m_tdata[5]), 16'(want.sum2_bad));
                    check_field("id_mismatch", 16'(m_tdata[6]), 16'(want.id_mismatch));
                    check_field("record_bad", 16'(m_tdata[7]), 16'(want.record_bad));
                    check_field("record_number", m_tdata[23:8], want.record_number);
                end
            end
        end
    end

    initial begin
        logic [16:0] row;
        logic [31:0] wdata;
        logic [31:0] rdata;
        int n;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        aresetn  = 1'b0;
        mismatches       = 0;
        directed_records = 0;
        hold_requests    = 0;
        hold_served      = 0;
        send_idle_pct    = 38;
        recv_idle_pct    = 51;
        lines_cfg        = LPS_WITH_NAME;
        record_cnt       = '0;
        restart_set();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 22; i++) begin
            row = DIRECTED_ROWS[i];
            send_item(row[7:0], row[8], row[16], row[15:9]);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 1)
                apb_write(SPARE_ADDR, $urandom());
            wdata      = $urandom();
            wdata[1:0] = PHASE_LPS[p];
            apb_write(LPS_ADDR, wdata);
            apb_read(LPS_ADDR, rdata);
            if (rdata !== {30'd0, PHASE_LPS[p]})
                flag_mismatch($sformatf("lines_per_set reads %0h", rdata));
            if (p == 2) begin
                send_idle_pct = 51;
                recv_idle_pct = 38;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests++;
            end
            phase_items   = 0;
            phase_records = 0;
            while (phase_items < PHASE_ITEMS || phase_records < PHASE_RECORDS)
                send_random_set();
            // Leave a line open now and then, so the register write lands mid-set.
            if ($urandom_range(1) == 1) begin
                build_line(1, $urandom_range(99999), 1'b0);
                n = $urandom_range(3, 40);
                for (int k = 0; k < n; k++)
                    send_item(line_buf[k], 1'b0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("tle_record_integrity_checker test passed");
        else
            $display("tle_record_integrity_checker test failed");
        $finish;
    end

endmodule
